FILE: src/fan_tach_count_to_rpm_assert.svh
// Assertion macros shared by the checker file of this block.
`ifndef FAN_TACH_COUNT_TO_RPM_ASSERT_SVH
`define FAN_TACH_COUNT_TO_RPM_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define FTC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define FTC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Same-cycle implication that is also checked during reset.
`define FTC_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

FILE: src/ftc_pkg.sv
package ftc_pkg;

   // Numerator of the speed formula and the stuck-count codes.
   localparam int unsigned SPEED_NUM        = 1350000;
   localparam int unsigned RPM_W            = 21;
   localparam int unsigned QUOT_DEPTH       = 256;
   localparam logic [7:0]  COUNT_STUCK_LOW  = 8'h00;
   localparam logic [7:0]  COUNT_STUCK_HIGH = 8'hFF;
   localparam logic [1:0]  LOW_EXP_MASK     = 2'b11;

   // Fan selector codes.
   localparam logic [1:0] FAN_1 = 2'd0;
   localparam logic [1:0] FAN_2 = 2'd1;
   localparam logic [1:0] FAN_3 = 2'd2;

   // Word after exponent decode.
   typedef struct packed {
      logic       valid;
      logic       ok;
      logic [7:0] count;
      logic [2:0] exp;
   } decode_type;

   // Word after the quotient lookup.
   typedef struct packed {
      logic             valid;
      logic             ok;
      logic [2:0]       exp;
      logic [RPM_W-1:0] quot;
   } quot_type;

endpackage

FILE: src/ftc_decode.sv
module ftc_decode (
   input  logic                clock,
   input  logic                reset,
   input  logic                extended,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [1:0]          fan_select,
   input  logic [7:0]          tach_count,
   input  logic [7:0]          fandiv_byte,
   input  logic [7:0]          pin_byte,
   input  logic [7:0]          battery_byte,
   output ftc_pkg::decode_type out_word,
   input  logic                out_ready
);
   import ftc_pkg::*;

   decode_type dec_ff;
   decode_type dec_in;
   logic [1:0] lo_exp;
   logic       hi_exp;
   logic       sel_ok;

   // Pick the divider bits of the selected fan.
   always_comb begin
      lo_exp = 2'b00;
      hi_exp = 1'b0;
      sel_ok = 1'b1;
      case (fan_select)
         FAN_1: begin
            lo_exp = fandiv_byte[5:4] & LOW_EXP_MASK;
            hi_exp = battery_byte[5];
         end
         FAN_2: begin
            lo_exp = fandiv_byte[7:6] & LOW_EXP_MASK;
            hi_exp = battery_byte[6];
         end
         FAN_3: begin
            lo_exp = pin_byte[7:6] & LOW_EXP_MASK;
            hi_exp = battery_byte[7];
         end
         default: begin
            sel_ok = 1'b0;
         end
      endcase
   end

   // A stuck count or a missing fan gives an invalid reading.
   always_comb begin
      dec_in.valid = in_valid;
      dec_in.ok    = sel_ok && (tach_count != COUNT_STUCK_LOW)
                     && (tach_count != COUNT_STUCK_HIGH);
      dec_in.count = tach_count;
      dec_in.exp   = {hi_exp & extended, lo_exp};
   end

   // The stage takes a word when it is empty or its word moves on.
   assign in_ready = !dec_ff.valid || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_ff.valid <= 1'b0;
      end else if (in_ready) begin
         dec_ff <= dec_in;
      end
   end

   assign out_word = dec_ff;

endmodule

FILE: src/ftc_quot.sv
module ftc_quot (
   input  logic                clock,
   input  logic                reset,
   input  ftc_pkg::decode_type in_word,
   output logic                in_ready,
   output ftc_pkg::quot_type   out_word,
   input  logic                out_ready
);
   import ftc_pkg::*;

   logic [RPM_W-1:0] quot_table [QUOT_DEPTH];
   quot_type         quot_ff;
   quot_type         quot_in;

   // Constant table of the numerator over each count; a zero count
   // never reaches the result, so its entry uses a divisor of one.
   for (genvar k = 0; k < QUOT_DEPTH; k++) begin : g_table
      localparam int unsigned DIVISOR = (k == 0) ? 1 : k;
      localparam logic [RPM_W-1:0] QUOT = RPM_W'(SPEED_NUM / DIVISOR);
      assign quot_table[k] = QUOT;
   end

   always_comb begin
      quot_in.valid = in_word.valid;
      quot_in.ok    = in_word.ok;
      quot_in.exp   = in_word.exp;
      quot_in.quot  = quot_table[in_word.count];
   end

   assign in_ready = !quot_ff.valid || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         quot_ff.valid <= 1'b0;
      end else if (in_ready) begin
         quot_ff <= quot_in;
      end
   end

   assign out_word = quot_ff;

endmodule

FILE: src/fan_tach_count_to_rpm.sv
// Channel  Direction  Word fields (low bit first)
// req      in         tdata: tach_count, fandiv_byte, pin_byte, battery_byte;
//                     tuser: fan_select
// rsp      out        tdata: rpm (21 bits, zero padded to 24); tuser: valid_res
// csr      in         csr_wdata: extended_divider, written when csr_we is high
//
// One word is accepted every cycle unless a stall on rsp has filled all three stages.
// A word is registered in turn by the decode, table lookup and shift registers and
// shows on rsp from the last of them.
// The rpm is the table value of 1350000 over the count shifted right by the
// divider exponent. Reset is synchronous and clears the pipeline and the
// divider mode. A stall on rsp holds the result register. A stage waits only when
// it and every stage after it are full and rsp stalls, so only then does req drop.
module fan_tach_count_to_rpm (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_wdata,      // extended_divider
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,      // tach_count, fandiv_byte, pin_byte, battery_byte
   input  logic [1:0]  req_tuser,      // fan_select
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,      // rpm, zero padding
   output logic [0:0]  rsp_tuser       // valid_res
);
   import ftc_pkg::*;

   logic             extended_ff;
   decode_type       dec_word;
   quot_type         quot_word;
   logic             quot_ready;
   logic             rsp_ready;
   logic             rsp_valid_ff;
   logic             rsp_ok_ff;
   logic [RPM_W-1:0] rpm_ff;
   logic [RPM_W-1:0] rpm_in;

   // Divider mode register.
   always_ff @(posedge clock) begin
      if (reset) begin
         extended_ff <= 1'b0;
      end else if (csr_we) begin
         extended_ff <= csr_wdata;
      end
   end

   // Stage one: exponent and validity decode.
   ftc_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .extended     (extended_ff),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .fan_select   (req_tuser),
      .tach_count   (req_tdata[7:0]),
      .fandiv_byte  (req_tdata[15:8]),
      .pin_byte     (req_tdata[23:16]),
      .battery_byte (req_tdata[31:24]),
      .out_word     (dec_word),
      .out_ready    (quot_ready)
   );

   // Stage two: quotient lookup by count.
   ftc_quot u_quot (
      .clock     (clock),
      .reset     (reset),
      .in_word   (dec_word),
      .in_ready  (quot_ready),
      .out_word  (quot_word),
      .out_ready (rsp_ready)
   );

   // Stage three: divide by the power of two and zero invalid readings.
   assign rpm_in    = quot_word.ok ? (quot_word.quot >> quot_word.exp) : '0;
   assign rsp_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_ready) begin
         rsp_valid_ff <= quot_word.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_ready) begin
         rpm_ff    <= rpm_in;
         rsp_ok_ff <= quot_word.ok;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {3'b000, rpm_ff};
   assign rsp_tuser[0] = rsp_ok_ff;

endmodule

FILE: src/ftc_checker.sv
module ftc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);
   import ftc_pkg::*;

   `include "fan_tach_count_to_rpm_assert.svh"

   // An invalid reading always reports zero speed.
   `FTC_ASSERT_NOW(a_invalid_zero, clock, reset, rsp_tvalid && !rsp_tuser[0], rsp_tdata == 24'd0, "invalid reading with nonzero rpm")

   // A valid reading lies between the slowest and fastest possible speeds.
   `FTC_ASSERT_NOW(a_valid_range, clock, reset, rsp_tvalid && rsp_tuser[0], (rsp_tdata[20:0] != 21'd0) && (rsp_tdata[20:0] <= 21'(SPEED_NUM)) && (rsp_tdata[23:21] == 3'd0), "valid rpm out of range")

   // A stalled result holds.
   `FTC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")

   // Nothing comes out in the cycle after reset.
   `FTC_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset), !rsp_tvalid, "result right after reset")

endmodule

bind fan_tach_count_to_rpm ftc_checker u_ftc_checker (.*);

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import ftc_pkg::*;

   // There is no fourth fan, so this selector must read as invalid.
   localparam logic [1:0] FAN_NONE    = 2'd3;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned DRAIN_WAIT  = 6;

   typedef struct packed {
      logic [1:0] fan;
      logic [7:0] count;
      logic [7:0] fandiv;
      logic [7:0] pin;
      logic [7:0] battery;
   } reading_type;

   typedef struct packed {
      logic [RPM_W-1:0] rpm;
      logic             ok;
   } speed_type;

   // Scoreboard: predicts the speed of each accepted word and checks results in order.
   class speed_scoreboard;
      bit        extended;
      int        errors;
      speed_type expected_speeds[$];

      function new();
         extended = 1'b0;
         errors   = 0;
      endfunction

      function speed_type predict_speed(reading_type r);
         speed_type   s;
         logic [1:0]  lo;
         logic        hi;
         int unsigned denom;
         s.ok  = 1'b1;
         s.rpm = '0;
         lo    = 2'b00;
         hi    = 1'b0;
         case (r.fan)
            FAN_1: begin
               lo = r.fandiv[5:4];
               hi = r.battery[5];
            end
            FAN_2: begin
               lo = r.fandiv[7:6];
               hi = r.battery[6];
            end
            FAN_3: begin
               lo = r.pin[7:6];
               hi = r.battery[7];
            end
            default: begin
               s.ok = 1'b0;
            end
         endcase
         if (!extended) begin
            hi = 1'b0;
         end
         if (r.count == COUNT_STUCK_LOW || r.count == COUNT_STUCK_HIGH) begin
            s.ok = 1'b0;
         end
         if (s.ok) begin
            denom = int'(r.count) << {hi, lo};
            s.rpm = RPM_W'(SPEED_NUM / denom);
         end
         return s;
      endfunction

      function void note_reading(reading_type r);
         expected_speeds.push_back(predict_speed(r));
      endfunction

      function void check_result(logic [23:0] tdata, logic [0:0] tuser);
         speed_type want;
         if (expected_speeds.size() == 0) begin
            $display("%0t: result with nothing expected: rpm %0d valid %0b",
                     $time, tdata[RPM_W-1:0], tuser[0]);
            errors++;
            return;
         end
         want = expected_speeds.pop_front();
         if (tdata[RPM_W-1:0] !== want.rpm) begin
            $display("%0t: rpm mismatch: expected %0d, actual %0d",
                     $time, want.rpm, tdata[RPM_W-1:0]);
            errors++;
         end
         if (tuser[0] !== want.ok) begin
            $display("%0t: valid_res mismatch: expected %0b, actual %0b",
                     $time, want.ok, tuser[0]);
            errors++;
         end
      endfunction

      function int pending();
         return expected_speeds.size();
      endfunction
   endclass

   logic        clock;
   logic        reset      = 1'b1;
   logic        csr_we     = 1'b0;
   logic        csr_wdata  = 1'b0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // tach_count, fandiv_byte, pin_byte, battery_byte
   logic [1:0]  req_tuser  = '0;   // fan_select
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // rpm, zero padding
   logic [0:0]  rsp_tuser;         // valid_res

   speed_scoreboard sb = new();
   int unsigned     cycles = 0;

   fan_tach_count_to_rpm i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watch both channels and feed the scoreboard.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            sb.note_reading('{fan: req_tuser, count: req_tdata[7:0],
                              fandiv: req_tdata[15:8], pin: req_tdata[23:16],
                              battery: req_tdata[31:24]});
         end
         if (rsp_tvalid && rsp_tready) begin
            sb.check_result(rsp_tdata, rsp_tuser);
         end
      end
   end

   // Receiver stalls on a duty pattern that is redrawn at random.
   int unsigned stall_period = 4;
   int unsigned stall_len    = 0;
   int unsigned stall_phase  = 0;
   always @(posedge clock) begin
      if (cycles % 50 == 0) begin
         stall_period = $urandom_range(2, 8);
         stall_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, stall_period - 1);
      end
      stall_phase = (stall_phase + 1) % stall_period;
      rsp_tready <= (stall_phase >= stall_len);
   end

   // Give up if the run hangs.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   function automatic reading_type make_reading(logic [1:0] fan, logic [7:0] count,
                                                logic [7:0] fandiv, logic [7:0] pin,
                                                logic [7:0] battery);
      reading_type r;
      r = '{fan: fan, count: count, fandiv: fandiv, pin: pin, battery: battery};
      return r;
   endfunction

   // Mostly real fans and live counts, with stuck counts and the missing fan mixed in.
   function automatic reading_type random_reading();
      reading_type r;
      int unsigned pick;
      r.fan = ($urandom_range(0, 15) == 0) ? FAN_NONE : 2'($urandom_range(0, 2));
      pick  = $urandom_range(0, 19);
      if (pick == 0) begin
         r.count = COUNT_STUCK_LOW;
      end else if (pick == 1) begin
         r.count = COUNT_STUCK_HIGH;
      end else if (pick == 2) begin
         r.count = 8'd1;
      end else begin
         r.count = 8'($urandom_range(1, 254));
      end
      r.fandiv  = 8'($urandom);
      r.pin     = 8'($urandom);
      r.battery = 8'($urandom);
      return r;
   endfunction

   // Present one word and hold it until the block takes it.
   task automatic put_word(reading_type r);
      req_tvalid <= 1'b1;
      req_tdata  <= {r.battery, r.pin, r.fandiv, r.count};
      req_tuser  <= r.fan;
      do @(posedge clock); while (!req_tready);
   endtask

   // Random words in bursts of random length with random gaps.
   task automatic send_random(int unsigned n);
      int unsigned burst_left;
      burst_left = $urandom_range(1, 24);
      for (int unsigned i = 0; i < n; i++) begin
         put_word(random_reading());
         burst_left--;
         if (burst_left == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
            burst_left = $urandom_range(1, 24);
         end
      end
   endtask

   // Let every result drain, then change the divider mode.
   task automatic drain_then_write(logic mode);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= mode;
      @(posedge clock);
      csr_we      <= 1'b0;
      sb.extended  = mode;
   endtask

   initial begin
      logic [1:0] fans[4];
      fans = '{FAN_1, FAN_2, FAN_3, FAN_NONE};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Normal mode: the battery bits must be ignored even when all set.
      drain_then_write(1'b0);
      put_word(make_reading(FAN_1, 8'd1, 8'hFF, 8'hFF, 8'hFF));
      put_word(make_reading(FAN_2, 8'd1, 8'hFF, 8'hFF, 8'hFF));
      put_word(make_reading(FAN_3, 8'd1, 8'hFF, 8'hFF, 8'hFF));

      // Extended mode: each fan at the fastest and slowest readings and stuck counts.
      drain_then_write(1'b1);
      foreach (fans[k]) begin
         put_word(make_reading(fans[k], 8'd1, 8'h00, 8'h00, 8'h00));
         put_word(make_reading(fans[k], COUNT_STUCK_HIGH, 8'hFF, 8'hFF, 8'hFF));
         put_word(make_reading(fans[k], COUNT_STUCK_LOW, 8'hFF, 8'hFF, 8'hFF));
         put_word(make_reading(fans[k], 8'd254, 8'hFF, 8'hFF, 8'hFF));
      end

      send_random(250);
      drain_then_write(1'b0);
      send_random(200);
      drain_then_write(1'b1);
      send_random(150);

      // Wait for the pipeline to empty, then a few quiet cycles for strays.
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+src
src/ftc_pkg.sv
src/ftc_decode.sv
src/ftc_quot.sv
src/fan_tach_count_to_rpm.sv
src/ftc_checker.sv
tb/tb.sv
